FILE: rtl/core/subtractive_lagged_rng_defines.svh
// Assertion macros shared by the subtractive lagged generator modules.
`ifndef SUBTRACTIVE_LAGGED_RNG_DEFINES_SVH
`define SUBTRACTIVE_LAGGED_RNG_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLRNG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLRNG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/slrng_pkg.sv
// Types and constants shared by the subtractive lagged generator modules.
package slrng_pkg;

    localparam int unsigned VAL_W   = 22;
    localparam int unsigned PTR_W   = 6;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned SHIFT_W = 4;

    localparam logic [CNT_W-1:0] MOD_STEPS_LAST  = 8'd9;
    localparam logic [CNT_W-1:0] FILL_STEPS_LAST = 8'd53;
    localparam logic [CNT_W-1:0] WARM_STEPS_LAST = 8'd219;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_FILL_HEAD,
        ST_FILL,
        ST_WARM,
        ST_WARM_END,
        ST_DRAW_RD,
        ST_DRAW_WR
    } slrng_state_t;

    typedef struct packed {
        logic               load_seed;
        logic               mod_step;
        logic [SHIFT_W-1:0] mod_shift;
        logic               fill_start;
        logic               fill_step;
        logic               warm_rd;
        logic               set_ptrs;
        logic               draw_rd;
        logic               draw_wr;
    } slrng_cmd_t;

endpackage

FILE: rtl/core/slrng_ctrl.sv
// Sequencer for seed reduction, table rebuild, warm-up passes and draws.
`include "subtractive_lagged_rng_defines.svh"

module slrng_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    seed_neg,
    output logic                    in_ready,
    input  logic                    out_free,
    output slrng_pkg::slrng_cmd_t   cmd
);

    slrng_pkg::slrng_state_t           state_reg;
    slrng_pkg::slrng_state_t           state_next;
    logic [slrng_pkg::CNT_W-1:0]       cnt_reg;
    logic [slrng_pkg::CNT_W-1:0]       cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slrng_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            slrng_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_seed = 1'b1;
                    if (seed_neg)
                    begin
                        state_next = slrng_pkg::ST_MOD;
                        cnt_next   = slrng_pkg::MOD_STEPS_LAST;
                    end
                    else
                    begin
                        cmd.draw_rd = 1'b1;
                        state_next  = slrng_pkg::ST_DRAW_WR;
                    end
                end
            end
            slrng_pkg::ST_MOD:
            begin
                cmd.mod_step  = 1'b1;
                cmd.mod_shift = cnt_reg[slrng_pkg::SHIFT_W-1:0];
                if (cnt_reg == '0)
                begin
                    state_next = slrng_pkg::ST_FILL_HEAD;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            slrng_pkg::ST_FILL_HEAD:
            begin
                cmd.fill_start = 1'b1;
                state_next     = slrng_pkg::ST_FILL;
                cnt_next       = slrng_pkg::FILL_STEPS_LAST;
            end
            slrng_pkg::ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = slrng_pkg::ST_WARM;
                    cnt_next   = slrng_pkg::WARM_STEPS_LAST;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            slrng_pkg::ST_WARM:
            begin
                cmd.warm_rd = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = slrng_pkg::ST_WARM_END;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            slrng_pkg::ST_WARM_END:
            begin
                cmd.set_ptrs = 1'b1;
                state_next   = slrng_pkg::ST_DRAW_RD;
            end
            slrng_pkg::ST_DRAW_RD:
            begin
                cmd.draw_rd = 1'b1;
                state_next  = slrng_pkg::ST_DRAW_WR;
            end
            slrng_pkg::ST_DRAW_WR:
            begin
                if (out_free)
                begin
                    cmd.draw_wr = 1'b1;
                    state_next  = slrng_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = slrng_pkg::ST_IDLE;
            end
        endcase
    end

    `SLRNG_ASSERT_NEXT(a_mod_to_fill, (state_reg == slrng_pkg::ST_MOD) && (cnt_reg == '0), state_reg == slrng_pkg::ST_FILL_HEAD, "Seed reduction did not hand over to the table fill.")
    `SLRNG_ASSERT_NEXT(a_warm_to_draw, state_reg == slrng_pkg::ST_WARM_END, state_reg == slrng_pkg::ST_DRAW_RD, "Warm-up end was not followed by a draw.")

endmodule

FILE: rtl/core/slrng_dp.sv
// Datapath with lag table memory, seed reduction, pointers and result register.
`include "subtractive_lagged_rng_defines.svh"

module slrng_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  slrng_pkg::slrng_cmd_t           cmd,
    input  logic [31:0]                     seed,
    output logic                            out_free,
    output logic                            out_valid,
    output logic [slrng_pkg::VAL_W-1:0]     value,
    input  logic                            out_ready
);

    localparam logic [slrng_pkg::VAL_W-1:0] MODULUS   = 22'd4000000;
    localparam logic [31:0]                 MODULUS_W = 32'd4000000;
    localparam logic [31:0]                 SEED_BIAS = 32'd2149618033;
    localparam logic [slrng_pkg::PTR_W-1:0] TBL_LEN   = 6'd55;
    localparam logic [slrng_pkg::PTR_W-1:0] STRIDE    = 6'd21;
    localparam logic [slrng_pkg::PTR_W-1:0] LAG       = 6'd31;
    localparam logic [slrng_pkg::PTR_W-1:0] FOLD      = 6'd24;

    function automatic logic [slrng_pkg::VAL_W-1:0] wrap_sub(
        input logic [slrng_pkg::VAL_W-1:0] a,
        input logic [slrng_pkg::VAL_W-1:0] b
    );
        logic [slrng_pkg::VAL_W:0] diff;
        diff = {1'b0, a} - {1'b0, b};
        if (diff[slrng_pkg::VAL_W])
        begin
            diff = diff + {1'b0, MODULUS};
        end
        return diff[slrng_pkg::VAL_W-1:0];
    endfunction

    function automatic logic [slrng_pkg::PTR_W-1:0] advance(
        input logic [slrng_pkg::PTR_W-1:0] p
    );
        logic [slrng_pkg::PTR_W-1:0] n;
        n = p + 1'b1;
        if (n > TBL_LEN)
        begin
            n = 6'd1;
        end
        return n;
    endfunction

    logic [slrng_pkg::VAL_W-1:0]    mem [0:55];
    logic [slrng_pkg::VAL_W-1:0]    rd_a_reg;
    logic [slrng_pkg::VAL_W-1:0]    rd_b_reg;
    logic [31:0]                    x_reg;
    logic [slrng_pkg::VAL_W-1:0]    j_reg;
    logic [slrng_pkg::VAL_W-1:0]    k_reg;
    logic [slrng_pkg::PTR_W-1:0]    idx_reg;
    logic [slrng_pkg::PTR_W-1:0]    warm_i_reg;
    logic [slrng_pkg::PTR_W-1:0]    wr_addr_reg;
    logic                           wr_pend_reg;
    logic [slrng_pkg::PTR_W-1:0]    near_reg;
    logic [slrng_pkg::PTR_W-1:0]    far_reg;
    logic                           seeded_reg;
    logic                           out_valid_reg;
    logic [slrng_pkg::VAL_W-1:0]    value_reg;

    logic [31:0]                    mod_sub;
    logic [slrng_pkg::VAL_W-1:0]    a_val;
    logic [slrng_pkg::VAL_W-1:0]    b_val;
    logic [slrng_pkg::VAL_W-1:0]    diff_ab;
    logic [slrng_pkg::PTR_W-1:0]    warm_other;
    logic [slrng_pkg::PTR_W-1:0]    near_adv;
    logic [slrng_pkg::PTR_W-1:0]    far_adv;
    logic [slrng_pkg::PTR_W:0]      idx_sum;
    logic [slrng_pkg::PTR_W-1:0]    idx_next;
    logic                           rd_en;
    logic [slrng_pkg::PTR_W-1:0]    rd_addr_a;
    logic [slrng_pkg::PTR_W-1:0]    rd_addr_b;
    logic                           wr_en;
    logic [slrng_pkg::PTR_W-1:0]    wr_addr;
    logic [slrng_pkg::VAL_W-1:0]    wr_data;

    // Until the first rebuild the table memory is not initialised, so reads are forced to zero.
    assign a_val      = seeded_reg ? rd_a_reg : '0;
    assign b_val      = seeded_reg ? rd_b_reg : '0;
    assign diff_ab    = wrap_sub(a_val, b_val);
    assign mod_sub    = MODULUS_W << cmd.mod_shift;
    assign warm_other = (warm_i_reg > FOLD) ? (warm_i_reg - FOLD) : (warm_i_reg + LAG);
    assign near_adv   = advance(near_reg);
    assign far_adv    = advance(far_reg);
    assign idx_sum    = {1'b0, idx_reg} + {1'b0, STRIDE};
    assign idx_next   = (idx_sum >= {1'b0, TBL_LEN}) ?
                        (idx_sum[slrng_pkg::PTR_W-1:0] - TBL_LEN) :
                        idx_sum[slrng_pkg::PTR_W-1:0];

    assign rd_en     = cmd.warm_rd | cmd.draw_rd;
    assign rd_addr_a = cmd.draw_rd ? near_adv : warm_i_reg;
    assign rd_addr_b = cmd.draw_rd ? far_adv : warm_other;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = wr_addr_reg;
        wr_data = diff_ab;
        if (cmd.fill_start)
        begin
            wr_en   = 1'b1;
            wr_addr = TBL_LEN;
            wr_data = x_reg[slrng_pkg::VAL_W-1:0];
        end
        else if (cmd.fill_step)
        begin
            wr_en   = 1'b1;
            wr_addr = idx_reg;
            wr_data = k_reg;
        end
        else if (wr_pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = wr_addr_reg;
        end
        else if (cmd.draw_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = near_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_seed)
        begin
            x_reg <= seed + SEED_BIAS;
        end
        else if (cmd.mod_step && (x_reg >= mod_sub))
        begin
            x_reg <= x_reg - mod_sub;
        end
        if (cmd.fill_start)
        begin
            j_reg      <= x_reg[slrng_pkg::VAL_W-1:0];
            k_reg      <= 22'd1;
            idx_reg    <= STRIDE;
            warm_i_reg <= 6'd1;
        end
        else if (cmd.fill_step)
        begin
            k_reg   <= wrap_sub(j_reg, k_reg);
            j_reg   <= k_reg;
            idx_reg <= idx_next;
        end
        else if (cmd.warm_rd)
        begin
            warm_i_reg  <= (warm_i_reg == TBL_LEN) ? 6'd1 : (warm_i_reg + 1'b1);
            wr_addr_reg <= warm_i_reg;
        end
        if (cmd.draw_wr)
        begin
            value_reg <= diff_ab;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pend_reg   <= 1'b0;
            near_reg      <= '0;
            far_reg       <= '0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= cmd.warm_rd;
            if (cmd.set_ptrs)
            begin
                near_reg <= '0;
                far_reg  <= LAG;
            end
            else if (cmd.draw_rd)
            begin
                near_reg <= near_adv;
                far_reg  <= far_adv;
            end
            if (cmd.fill_start)
            begin
                seeded_reg <= 1'b1;
            end
            if (cmd.draw_wr)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    `SLRNG_ASSERT_IMPL(a_value_range, out_valid_reg, value_reg < MODULUS, "Result value is not below the modulus.")
    `SLRNG_ASSERT_IMPL(a_fill_index, cmd.fill_step, (idx_reg != 6'd0) && (idx_reg < TBL_LEN), "Fill index left the range 1 to 54.")
    `SLRNG_ASSERT_IMPL(a_pointer_lag, cmd.draw_wr && seeded_reg, far_reg == ((near_reg > FOLD) ? (near_reg - FOLD) : (near_reg + LAG)), "Far pointer lost its lag to the near pointer.")

endmodule

FILE: rtl/core/subtractive_lagged_rng.sv
// Subtractive lagged random generator: takes no new seed until the last draw is written to the result register.
// A draw reads two table entries on the memory's two read ports, then writes one back.
// A negative seed first runs the seed reduction, the table fill, the pipelined warm-up
// passes and a restart of the pointers before its draw.
// After reset the table reads as zeros and both pointers are zero, so draws give 0
// until a negative seed rebuilds the table; no clearing pass is needed.
module subtractive_lagged_rng
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // seed[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata     // value[21:0], zeros[23:22]
);

    slrng_pkg::slrng_cmd_t          cmd;
    logic                           out_free;
    logic [slrng_pkg::VAL_W-1:0]    value;

    slrng_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .seed_neg (s_tdata[31]),
        .in_ready (s_tready),
        .out_free (out_free),
        .cmd      (cmd)
    );

    slrng_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .seed      (s_tdata),
        .out_free  (out_free),
        .out_valid (m_tvalid),
        .value     (value),
        .out_ready (m_tready)
    );

    assign m_tdata = {2'b00, value};

endmodule

FILE: tb/sv/subtractive_lagged_rng_tb.sv
// Testbench for the subtractive lagged generator: predicts every draw and checks each result.
`timescale 1ns / 100ps

class rng_scoreboard;
    localparam int MODULUS   = 4000000;
    localparam int SEED_BASE = 1618033;
    localparam int TABLE_LEN = 55;
    localparam int STRIDE    = 21;
    localparam int LAG       = 31;
    localparam int OFFSET    = 30;

    logic [slrng_pkg::VAL_W-1:0]  lag_entries [1:TABLE_LEN];
    logic [slrng_pkg::PTR_W-1:0]  near_ptr;
    logic [slrng_pkg::PTR_W-1:0]  far_ptr;
    logic [slrng_pkg::VAL_W-1:0]  draws_due [$];
    int                           errors;

    function void clear_state();
        for (int i = 1; i <= TABLE_LEN; i++)
        begin
            lag_entries[i] = '0;
        end
        near_ptr = '0;
        far_ptr  = '0;
        draws_due.delete();
        errors = 0;
    endfunction

    function int wrap_sub(int a, int b);
        int d;
        d = a - b;
        if (d < 0)
        begin
            d += MODULUS;
        end
        return d;
    endfunction

    function logic [slrng_pkg::PTR_W-1:0] step_ptr(logic [slrng_pkg::PTR_W-1:0] p);
        logic [slrng_pkg::PTR_W-1:0] n;
        n = p + 1'b1;
        if (n > TABLE_LEN || n == 0)
        begin
            n = 6'd1;
        end
        return n;
    endfunction

    function void rebuild_table(logic signed [31:0] seed);
        longint start;
        int     jv;
        int     kv;
        int     idx;
        int     other;
        start = (longint'(SEED_BASE) + longint'(seed)) % MODULUS;
        if (start < 0)
        begin
            start += MODULUS;
        end
        jv = int'(start);
        lag_entries[TABLE_LEN] = jv[slrng_pkg::VAL_W-1:0];
        kv = 1;
        for (int i = 1; i < TABLE_LEN; i++)
        begin
            idx = (STRIDE * i) % TABLE_LEN;
            lag_entries[idx] = kv[slrng_pkg::VAL_W-1:0];
            kv = wrap_sub(jv, kv);
            jv = int'(lag_entries[idx]);
        end
        for (int pass = 0; pass < 4; pass++)
        begin
            for (int i = 1; i <= TABLE_LEN; i++)
            begin
                other = 1 + ((i + OFFSET) % TABLE_LEN);
                idx = wrap_sub(int'(lag_entries[i]), int'(lag_entries[other]));
                lag_entries[i] = idx[slrng_pkg::VAL_W-1:0];
            end
        end
        near_ptr = '0;
        far_ptr  = 6'(LAG);
    endfunction

    function void note_seed(logic signed [31:0] seed);
        int d;
        if (seed < 0)
        begin
            rebuild_table(seed);
        end
        near_ptr = step_ptr(near_ptr);
        far_ptr  = step_ptr(far_ptr);
        d = wrap_sub(int'(lag_entries[near_ptr]), int'(lag_entries[far_ptr]));
        lag_entries[near_ptr] = d[slrng_pkg::VAL_W-1:0];
        draws_due.push_back(d[slrng_pkg::VAL_W-1:0]);
    endfunction

    task report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_value(logic [23:0] got);
        logic [slrng_pkg::VAL_W-1:0] want;
        if (draws_due.size() == 0)
        begin
            report_mismatch($sformatf("value %0d arrived with no draw pending", got));
        end
        else
        begin
            want = draws_due.pop_front();
            if (got !== {2'b00, want})
            begin
                report_mismatch($sformatf("value got %0d expected %0d", got, want));
            end
        end
    endtask
endclass

module subtractive_lagged_rng_tb;
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    rng_scoreboard sb = new();
    bit            steady = 1'b0;

    subtractive_lagged_rng u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= steady || ($urandom_range(99) >= 29);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_value(m_tdata);
        end
    end

    task automatic send_seed(input logic [31:0] seed);
        while (!steady && $urandom_range(99) < 29)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= seed;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sb.note_seed(seed);
    endtask

    task automatic send_draws(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(15) == 0)
            begin
                send_seed($urandom_range(1) ? 32'h7FFF_FFFF : 32'h0000_0000);
            end
            else
            begin
                send_seed({1'b0, 31'($urandom_range(32'h7FFF_FFFF))});
            end
        end
    endtask

    initial
    begin
        int sent;
        int burst;
        sb.clear_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Draws from the all-zero table, then reseeds at the seed extremes and at the
        // starts that reduce to zero, to a multiple of the modulus and to the top value.
        send_seed(32'h0000_0000);
        send_seed(32'h7FFF_FFFF);
        send_seed(32'h0000_0001);
        send_seed(-32'sd1);
        send_draws(3);
        send_seed(32'h8000_0000);
        send_draws(2);
        send_seed(-32'sd1618033);
        send_draws(2);
        send_seed(-32'sd5618033);
        send_draws(2);
        send_seed(-32'sd1618034);
        send_draws(2);
        send_seed(32'sd2381967);
        send_seed(-32'sd2);

        sent = 0;
        while (sent < 350)
        begin
            steady = (sent >= 200 && sent < 280);
            burst = $urandom_range(1, 80);
            send_draws(burst);
            if ($urandom_range(9) == 0)
            begin
                send_seed(32'h8000_0000);
            end
            else
            begin
                send_seed({1'b1, 31'($urandom_range(32'h7FFF_FFFF))});
            end
            sent += burst + 1;
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.draws_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/slrng_pkg.sv
rtl/core/slrng_ctrl.sv
rtl/core/slrng_dp.sv
rtl/core/subtractive_lagged_rng.sv
tb/sv/subtractive_lagged_rng_tb.sv
